@@ design/scbf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbf_pkg
// Shared constants, codes and control structs for the sector CBC Blowfish
// cipher core.
// ----------------------------------------------------------------------------
package scbf_pkg;

  // Sector geometry
  localparam int BLOCKS_PER_SECTOR = 64;
  localparam int BLK_W = $clog2(BLOCKS_PER_SECTOR + 1);

  // Key tables
  localparam int P_WORDS     = 18;
  localparam int S_BANKS     = 4;
  localparam int SBOX_DEPTH  = 256;
  localparam int S_WORDS     = S_BANKS * SBOX_DEPTH;
  localparam int IDX_W       = 11;
  localparam int P_IDX_W     = $clog2(P_WORDS);
  localparam int SBOX_AW     = $clog2(SBOX_DEPTH);
  localparam int BANK_W      = $clog2(S_BANKS);

  // Cipher sequencing: step 0 is the load, 1..16 the rounds, 17 the whitening
  localparam int ROUNDS      = 16;
  localparam int STEP_W      = 5;
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_FINAL = STEP_W'(ROUNDS + 1);

  // Request opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_NEWIV,
    ST_IV
  } ctl_state_t;

  // Command to the cipher engine
  typedef struct packed {
    logic start;
    logic dec;
    logic hold;
  } eng_cmd_t;

  // Status from the cipher engine
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

  // Key table write
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;
  } tbl_wr_t;

endpackage

@@ design/scbf_channels.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbf_channels
// Valid/ready channels of the sector cipher: request in, result out.
// ----------------------------------------------------------------------------
interface scbf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [10:0] table_index;
  logic [31:0] table_word;
  logic [63:0] start_sector;
  logic        direction;
  logic [63:0] data_block;

  modport source (
    output valid, opcode, table_index, table_word, start_sector, direction,
           data_block,
    input  ready
  );
  modport sink (
    input  valid, opcode, table_index, table_word, start_sector, direction,
           data_block,
    output ready
  );
endinterface

interface scbf_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_block;
  logic        last_of_sector;

  modport source (
    output valid, result_block, last_of_sector,
    input  ready
  );
  modport sink (
    input  valid, result_block, last_of_sector,
    output ready
  );
endinterface

@@ design/scbf_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbf_engine
// Blowfish block engine: P-array registers, four S-box banks with registered
// reads, and a one-round-per-cycle Feistel sequencer.
// ----------------------------------------------------------------------------
module scbf_engine
  import scbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  eng_cmd_t    cmd,
  input  logic [63:0] src_block,
  input  tbl_wr_t     tbl,
  output eng_stat_t   stat,
  output logic [63:0] crypt_block
);

  logic [31:0]             p_regs [0:P_WORDS-1];
  logic [S_BANKS-1:0][31:0] s_word;

  logic [31:0]        xl, xl_next;
  logic [31:0]        xr, xr_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               busy, busy_next;
  logic               dec, dec_next;

  logic               dec_sel;
  logic [STEP_W-1:0]  step_sel;
  logic [P_IDX_W-1:0] pidx;
  logic [31:0]        p_word;
  logic [31:0]        f_val;
  logic [IDX_W-1:0]   s_off;
  logic               s_hit;

  // Table write decode
  assign s_off = tbl.idx - IDX_W'(P_WORDS);
  assign s_hit = (tbl.idx >= IDX_W'(P_WORDS)) && (tbl.idx < IDX_W'(P_WORDS + S_WORDS));

  always_ff @(posedge clk) begin
    if (tbl.we && (tbl.idx < IDX_W'(P_WORDS))) begin
      p_regs[tbl.idx[P_IDX_W-1:0]] <= tbl.word;
    end
  end

  // S-box banks: bank 0 is indexed by the top byte of the half
  for (genvar b = 0; b < S_BANKS; b++) begin : g_bank
    logic [31:0]        mem [0:SBOX_DEPTH-1];
    logic [31:0]        rd_q;
    logic [SBOX_AW-1:0] raddr;

    assign raddr = xl_next[31-8*b -: SBOX_AW];

    always_ff @(posedge clk) begin
      if (tbl.we && s_hit && (s_off[SBOX_AW +: BANK_W] == BANK_W'(b))) begin
        mem[s_off[SBOX_AW-1:0]] <= tbl.word;
      end
      rd_q <= mem[raddr];
    end

    assign s_word[b] = rd_q;
  end

  // P-array index: forward order to encrypt, reverse to decrypt
  assign dec_sel  = busy ? dec : cmd.dec;
  assign step_sel = busy ? step : '0;
  assign pidx     = dec_sel ? P_IDX_W'(STEP_W'(P_WORDS - 1) - step_sel)
                            : P_IDX_W'(step_sel);
  assign p_word   = p_regs[pidx];

  // Round function from the registered S-box words
  assign f_val = ((s_word[0] + s_word[1]) ^ s_word[2]) + s_word[3];

  // Sequencer
  always_comb begin
    xl_next     = xl;
    xr_next     = xr;
    step_next   = step;
    busy_next   = busy;
    dec_next    = dec;
    stat.busy   = busy;
    stat.done   = 1'b0;
    crypt_block = {xr ^ p_word, xl};
    if (!busy) begin
      if (cmd.start) begin
        xl_next   = src_block[63:32] ^ p_word;
        xr_next   = src_block[31:0];
        step_next = STEP_FIRST;
        busy_next = 1'b1;
        dec_next  = cmd.dec;
      end
    end else if (step == STEP_FINAL) begin
      stat.done = 1'b1;
      if (!cmd.hold) begin
        busy_next = 1'b0;
      end
    end else begin
      xl_next   = xr ^ f_val ^ p_word;
      xr_next   = xl;
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      dec  <= 1'b0;
    end else begin
      busy <= busy_next;
      step <= step_next;
      dec  <= dec_next;
    end
  end

  always_ff @(posedge clk) begin
    xl <= xl_next;
    xr <= xr_next;
  end

endmodule

@@ design/sector_cbc_blowfish_cipher_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cbc_blowfish_cipher_core
// Disk sector cipher: Blowfish in CBC mode with one IV per sector.
//
// Requests load key table words (one word per cycle while idle), start a
// transfer at a sector number and direction, or carry 64-bit data blocks.
// Each Blowfish pass in the block engine loads the block, runs one round
// per cycle (the S-box banks are read once per cycle), then applies the
// output whitening. A data block is taken only after the previous pass is
// over; the next sector's IV is enciphered right after a sector's last block.
// A start request enciphers the sector's IV and gives no result.
// The result register lets the next request in while a result is waiting;
// a data block finishing while the previous result is still not taken
// holds in the engine. The key tables have no reset and must be loaded
// before use; there is no clearing pass.
// ----------------------------------------------------------------------------
module sector_cbc_blowfish_cipher_core
  import scbf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  scbf_req_if.sink    request,
  scbf_rsp_if.source  result
);

  localparam logic [BLK_W-1:0] LAST_BLK = BLK_W'(BLOCKS_PER_SECTOR - 1);

  ctl_state_t        state, state_next;
  logic [63:0]       chain, chain_next;
  logic [63:0]       sector, sector_next;
  logic [BLK_W-1:0]  blk_cnt, blk_next;
  logic              dec_mode, dec_next;
  logic [63:0]       data_hold, data_hold_next;
  logic              out_valid, out_valid_next;
  logic [63:0]       out_block, out_block_next;
  logic              out_last, out_last_next;

  eng_cmd_t          cmd;
  eng_stat_t         eng_stat;
  tbl_wr_t           tbl;
  logic [63:0]       eng_block;
  logic [63:0]       eng_result;
  logic              out_free;
  logic              is_last;
  logic              req_ready;

  // Sector number as bytes, least significant byte at the top
  function automatic logic [63:0] sector_bytes(input logic [63:0] s);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      v[63-8*i -: 8] = s[8*i +: 8];
    end
    return v;
  endfunction

  scbf_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .src_block   (eng_block),
    .tbl         (tbl),
    .stat        (eng_stat),
    .crypt_block (eng_result)
  );

  assign out_free       = !out_valid || result.ready;
  assign is_last        = (blk_cnt == LAST_BLK);
  assign request.ready  = req_ready;
  assign result.valid          = out_valid;
  assign result.result_block   = out_block;
  assign result.last_of_sector = out_last;

  // Request sequencing and chaining
  always_comb begin
    state_next     = state;
    chain_next     = chain;
    sector_next    = sector;
    blk_next       = blk_cnt;
    dec_next       = dec_mode;
    data_hold_next = data_hold;
    out_valid_next = out_valid && !result.ready;
    out_block_next = out_block;
    out_last_next  = out_last;
    cmd            = '0;
    tbl            = '0;
    eng_block      = '0;
    req_ready      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (request.valid) begin
          case (opcode_t'(request.opcode))
            OP_LOAD: begin
              tbl.we   = 1'b1;
              tbl.idx  = request.table_index;
              tbl.word = request.table_word;
            end
            OP_START: begin
              sector_next = request.start_sector;
              dec_next    = request.direction;
              blk_next    = '0;
              cmd.start   = 1'b1;
              eng_block   = sector_bytes(request.start_sector);
              state_next  = ST_IV;
            end
            OP_DATA: begin
              data_hold_next = request.data_block;
              cmd.start      = 1'b1;
              cmd.dec        = dec_mode;
              eng_block      = dec_mode ? request.data_block
                                        : (chain ^ request.data_block);
              state_next     = ST_DATA;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DATA: begin
        cmd.hold = !out_free;
        if (eng_stat.done && out_free) begin
          out_valid_next = 1'b1;
          out_last_next  = is_last;
          if (dec_mode) begin
            out_block_next = eng_result ^ chain;
            chain_next     = data_hold;
          end else begin
            out_block_next = eng_result;
            chain_next     = eng_result;
          end
          if (is_last) begin
            blk_next    = '0;
            sector_next = sector + 64'd1;
            state_next  = ST_NEWIV;
          end else begin
            blk_next   = blk_cnt + BLK_W'(1);
            state_next = ST_IDLE;
          end
        end
      end
      ST_NEWIV: begin
        cmd.start  = 1'b1;
        eng_block  = sector_bytes(sector);
        state_next = ST_IV;
      end
      ST_IV: begin
        if (eng_stat.done) begin
          chain_next = eng_result;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chain     <= '0;
      sector    <= '0;
      blk_cnt   <= '0;
      dec_mode  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chain     <= chain_next;
      sector    <= sector_next;
      blk_cnt   <= blk_next;
      dec_mode  <= dec_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data_hold <= data_hold_next;
    out_block <= out_block_next;
    out_last  <= out_last_next;
  end

  // Checks
  a_ready_engine_idle: assert property (@(posedge clk) disable iff (rst)
    request.ready |-> !eng_stat.busy)
    else $error("request taken while the engine is busy");

  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    eng_stat.done |-> (state == ST_DATA || state == ST_IV))
    else $error("engine finished outside a cipher pass");

  a_last_new_iv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DATA && eng_stat.done && out_free && is_last)
      |=> (state == ST_NEWIV && out_last && blk_cnt == '0))
    else $error("sector end did not start a new IV");

  a_blk_range: assert property (@(posedge clk) disable iff (rst)
    blk_cnt <= LAST_BLK)
    else $error("block counter past end of sector");

endmodule

@@ tb/sector_cbc_blowfish_cipher_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cbc_blowfish_cipher_core_tb
// Self-checking bench for the sector CBC Blowfish cipher core. The key tables
// are loaded in full first. Then a short directed list runs, followed by
// random transfers: start requests, data runs of varying length, table
// rewrites and ignored requests. A transaction-level predictor computes each
// expected block, and the monitor compares every result against it. Both
// channels idle at random, and the result side holds off for long stretches
// so that the core backs up onto its request input.
// ----------------------------------------------------------------------------
module sector_cbc_blowfish_cipher_core_tb;
  import scbf_pkg::*;

  localparam int RANDOM_ITEMS  = 480;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_SPACING  = 500;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    opcode_t     op;
    logic [10:0] index;
    logic [31:0] word;
    logic [63:0] sector;
    logic        dir;
    logic [63:0] block;
  } cipher_req_t;

  typedef struct {
    logic [63:0] block;
    logic        last;
  } cipher_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scbf_req_if request_ch ();
  scbf_rsp_if result_ch ();

  sector_cbc_blowfish_cipher_core dut (
    .clk     (clk),
    .rst     (rst),
    .request (request_ch),
    .result  (result_ch)
  );

  always #1 clk = ~clk;

  // Requests waiting to be offered, and blocks the core still owes us
  cipher_req_t request_backlog[$];
  cipher_rsp_t pending_results[$];

  int backlog_total;
  int setup_items;
  int items_sent    = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int hold_left     = 0;
  int next_hold_at  = 150;
  int quiet_cycles  = 0;

  // Predictor state: key tables, chaining value and sector position
  bit [31:0]   p_key [P_WORDS];
  bit [31:0]   s_key [S_WORDS];
  bit [63:0]   chain_reg;
  bit [63:0]   sector_reg;
  int unsigned blocks_done;
  bit          decrypting;

  // Blowfish round function over the four S-box banks
  function automatic bit [31:0] round_mix(bit [31:0] x);
    bit [31:0] a, b, c, d;
    a = s_key[x[31:24]];
    b = s_key[SBOX_DEPTH + x[23:16]];
    c = s_key[2 * SBOX_DEPTH + x[15:8]];
    d = s_key[3 * SBOX_DEPTH + x[7:0]];
    return ((a + b) ^ c) + d;
  endfunction

  function automatic bit [63:0] blowfish(bit [63:0] blk, bit dec);
    bit [31:0] l, r, t;
    int        i;
    l = blk[63:32];
    r = blk[31:0];
    for (i = 0; i < 16; i++) begin
      l ^= p_key[dec ? 17 - i : i];
      r ^= round_mix(l);
      t = l; l = r; r = t;
    end
    t = l; l = r; r = t;
    r ^= p_key[dec ? 1 : 16];
    l ^= p_key[dec ? 0 : 17];
    return {l, r};
  endfunction

  // IV: sector number laid out least significant byte first, enciphered
  function automatic bit [63:0] sector_iv(bit [63:0] sector);
    bit [63:0] v;
    int        i;
    v = '0;
    for (i = 0; i < 8; i++) v = {v[55:0], sector[8*i +: 8]};
    return blowfish(v, 1'b0);
  endfunction

  // Apply one accepted request to the predictor; data blocks queue a result
  function automatic void sector_cipher_step(cipher_req_t rq);
    cipher_rsp_t rs;
    case (rq.op)
      OP_LOAD: begin
        if (rq.index < P_WORDS) p_key[rq.index] = rq.word;
        else if (rq.index < P_WORDS + S_WORDS) s_key[rq.index - P_WORDS] = rq.word;
      end
      OP_START: begin
        sector_reg  = rq.sector;
        decrypting  = rq.dir;
        blocks_done = 0;
        chain_reg   = sector_iv(sector_reg);
      end
      OP_DATA: begin
        if (decrypting) begin
          rs.block  = blowfish(rq.block, 1'b1) ^ chain_reg;
          chain_reg = rq.block;
        end else begin
          chain_reg = blowfish(chain_reg ^ rq.block, 1'b0);
          rs.block  = chain_reg;
        end
        rs.last = 1'b0;
        blocks_done++;
        if (blocks_done >= BLOCKS_PER_SECTOR) begin
          rs.last     = 1'b1;
          blocks_done = 0;
          sector_reg  = sector_reg + 64'd1;
          chain_reg   = sector_iv(sector_reg);
        end
        pending_results.push_back(rs);
      end
      default: ;
    endcase
  endfunction

  // Stimulus builders; unused fields carry random bits
  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cipher_req_t noise_fields(opcode_t op);
    cipher_req_t rq;
    rq.op     = op;
    rq.index  = 11'($urandom);
    rq.word   = $urandom;
    rq.sector = rand64();
    rq.dir    = 1'($urandom);
    rq.block  = rand64();
    return rq;
  endfunction

  function automatic void push_load(logic [10:0] idx, logic [31:0] w);
    cipher_req_t rq;
    rq       = noise_fields(OP_LOAD);
    rq.index = idx;
    rq.word  = w;
    request_backlog.push_back(rq);
  endfunction

  function automatic void push_start(logic [63:0] sec, logic d);
    cipher_req_t rq;
    rq        = noise_fields(OP_START);
    rq.sector = sec;
    rq.dir    = d;
    request_backlog.push_back(rq);
  endfunction

  function automatic void push_data(logic [63:0] blk);
    cipher_req_t rq;
    rq       = noise_fields(OP_DATA);
    rq.block = blk;
    request_backlog.push_back(rq);
  endfunction

  function automatic bit [63:0] pick_block();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic bit [63:0] pick_sector();
    case ($urandom_range(0, 7))
      0:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1));
      1:       return 64'($urandom_range(0, 3));
      default: return rand64();
    endcase
  endfunction

  // Idle mix: 0 = light request gaps, 1 = heavy request gaps, 2 = no gaps
  function automatic int phase_of(int sent);
    int span;
    span = (backlog_total - setup_items) / 3;
    if (sent < setup_items + span) return 0;
    if (sent < setup_items + 2 * span) return 1;
    return 2;
  endfunction

  // Request driver
  always @(posedge clk) begin
    int ph;
    int gap_pct;
    cipher_req_t nxt;
    if (rst) begin
      request_ch.valid <= 1'b0;
    end else begin
      if (request_ch.valid && request_ch.ready) begin
        sector_cipher_step(request_backlog.pop_front());
        items_sent <= items_sent + 1;
      end
      if (!request_ch.valid || request_ch.ready) begin
        ph      = phase_of(items_sent);
        gap_pct = (ph == 0) ? 17 : (ph == 1) ? 53 : 0;
        if (request_backlog.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt                     = request_backlog[0];
          request_ch.opcode       <= nxt.op;
          request_ch.table_index  <= nxt.index;
          request_ch.table_word   <= nxt.word;
          request_ch.start_sector <= nxt.sector;
          request_ch.direction    <= nxt.dir;
          request_ch.data_block   <= nxt.block;
          request_ch.valid        <= 1'b1;
        end else begin
          request_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready driver
  always @(posedge clk) begin
    int ph;
    int gap_pct;
    cipher_rsp_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d: block %h last %b arrived with nothing expected",
                     results_seen, result_ch.result_block, result_ch.last_of_sector);
        end else begin
          want = pending_results.pop_front();
          if (result_ch.result_block !== want.block ||
              result_ch.last_of_sector !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected block %h last %b, got block %h last %b",
                       results_seen, want.block, want.last,
                       result_ch.result_block, result_ch.last_of_sector);
          end
        end
        results_seen++;
      end
      // Long hold-off lets the core fill up and stall requests
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (results_seen >= next_hold_at) begin
        hold_left       = HOLD_CYCLES;
        next_hold_at    = next_hold_at + HOLD_SPACING;
        result_ch.ready <= 1'b0;
      end else begin
        ph      = phase_of(items_sent);
        gap_pct = (ph == 0) ? 53 : (ph == 1) ? 17 : 0;
        result_ch.ready <= ($urandom_range(0, 99) >= gap_pct);
      end
    end
  end

  // Watchdog: too long with no request or result taken
  always @(posedge clk) begin
    if (!rst) begin
      if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("timeout: no traffic for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int i;
    int counted;
    int runlen;
    int k;

    request_ch.valid        = 1'b0;
    request_ch.opcode       = OP_LOAD;
    request_ch.table_index  = '0;
    request_ch.table_word   = '0;
    request_ch.start_sector = '0;
    request_ch.direction    = 1'b0;
    request_ch.data_block   = '0;
    result_ch.ready         = 1'b0;

    chain_reg   = '0;
    sector_reg  = '0;
    blocks_done = 0;
    decrypting  = 1'b0;

    // Whole key table first so nothing unwritten is ever read
    for (i = 0; i < P_WORDS + S_WORDS; i++) push_load(11'(i), $urandom);
    setup_items = request_backlog.size();

    // Directed: data before any start, ignored requests, extreme sectors
    push_data('0);
    push_data('1);
    push_load(11'h7FF, $urandom);
    push_load(11'(P_WORDS + S_WORDS), $urandom);
    request_backlog.push_back(noise_fields(OP_RSVD));
    push_start('1, 1'b0);
    push_data('0);
    push_data(rand64());
    push_data('1);
    push_start('0, 1'b1);
    push_data('1);
    push_data('0);
    push_data(rand64());
    push_start(rand64(), 1'b1);
    push_data(rand64());
    // Rewrite the first and last words of each table
    push_load(11'd0, $urandom);
    push_load(11'(P_WORDS - 1), $urandom);
    push_load(11'(P_WORDS), $urandom);
    push_load(11'(P_WORDS + S_WORDS - 1), $urandom);
    push_start(rand64(), 1'b0);
    push_data(rand64());

    // Random: mostly start + data runs; first run wraps the sector number
    push_start('1, 1'($urandom));
    for (k = 0; k < 70; k++) push_data(pick_block());
    counted = 71;
    while (counted < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: begin
          if ($urandom_range(0, 1) != 0)
            request_backlog.push_back(noise_fields(OP_RSVD));
          else
            push_load(11'($urandom_range(P_WORDS + S_WORDS, 2047)), $urandom);
        end
        1, 2: begin
          push_load(11'($urandom_range(0, P_WORDS + S_WORDS - 1)), $urandom);
          counted++;
        end
        3, 4: begin
          // Data continuing on the current chain
          runlen = $urandom_range(1, 12);
          for (k = 0; k < runlen; k++) push_data(pick_block());
          counted += runlen;
        end
        default: begin
          runlen = ($urandom_range(0, 3) == 0) ? $urandom_range(BLOCKS_PER_SECTOR, 140)
                                               : $urandom_range(1, 20);
          push_start(pick_sector(), 1'($urandom));
          for (k = 0; k < runlen; k++) push_data(pick_block());
          counted += runlen + 1;
        end
      endcase
    end
    backlog_total = request_backlog.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (items_sent != backlog_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
